FILE: rtl/postfix_expression_evaluator_unit_defines.svh
// Assertion macros shared by the postfix evaluator RTL.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Plain property check.
`define PEE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define PEE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pee_pkg.sv
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pee_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned STATUS_W    = 3;

  // ASCII codes the evaluator recognizes.
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CH_W-1:0] CH_DIV   = 8'h2F;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 3'd0,
    STATUS_UNDER   = 3'd1,
    STATUS_DIVZERO = 3'd2,
    STATUS_BADCH   = 3'd3,
    STATUS_OVER    = 3'd4
  } pee_status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_POP
  } pee_cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } pee_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } pee_div_state_e;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } pee_in_t;

  typedef struct packed {
    logic                     done_res;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
  } pee_out_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } pee_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } pee_div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/postfix_expression_evaluator_unit.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_unit
// Evaluates postfix expressions over a row of shifting stack cells.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per item and returns one result item per
// character; the result of the character flagged last carries the answer or
// the first error of the expression, after which the stack is empty again.
// Digits and the operators +, - and * are done as each is taken: the top two
// cells feed the arithmetic and the row of cells shifts in the same cycle.
// A division runs on the divider, which produces one quotient bit per cycle
// in its steps (a load, 32 restoring steps, a write-back).
// A new item is taken whenever no division runs and the output register is
// empty or being read in that cycle.
`default_nettype none

`include "postfix_expression_evaluator_unit_defines.svh"

module postfix_expression_evaluator_unit #(
  parameter int unsigned StackDepth = pee_pkg::STACK_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire pee_pkg::pee_in_t in_item_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output pee_pkg::pee_out_t out_item_o
);

  localparam int unsigned DataW = pee_pkg::DATA_W;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);

  pee_pkg::pee_state_e  state_q, state_d;
  pee_pkg::pee_status_e err_q, err_d, err_n, fin_err;
  logic [CntW-1:0]      count_q, count_d, cnt_n;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  pee_pkg::pee_out_t    out_q, out_d;

  logic [DataW-1:0]      cell_val [StackDepth];
  pee_pkg::pee_cell_op_e stack_op, top_op;

  logic                  in_acc, produce, fin_last, div_start, is_digit;
  logic [DataW-1:0]      top_n, opnd_a, opnd_b, digit_val;
  logic [DataW-1:0]      sum, dif, prod;
  pee_pkg::pee_div_req_t div_req;
  pee_pkg::pee_div_rsp_t div_rsp;

  // ---------------------------------------------------------------- stack
  assign top_op = (stack_op == pee_pkg::CELL_HOLD) ? pee_pkg::CELL_HOLD : pee_pkg::CELL_PUSH;

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    if (i == 0) begin : g_top
      pee_cell #(.DataW(DataW)) u_cell (
        .clk_i   (clk_i),
        .op_i    (top_op),
        .above_i (top_n),
        .below_i (cell_val[1]),
        .value_o (cell_val[0])
      );
    end else if (i == StackDepth - 1) begin : g_bottom
      pee_cell #(.DataW(DataW)) u_cell (
        .clk_i   (clk_i),
        .op_i    (stack_op),
        .above_i (cell_val[i-1]),
        .below_i (cell_val[i]),
        .value_o (cell_val[i])
      );
    end else begin : g_mid
      pee_cell #(.DataW(DataW)) u_cell (
        .clk_i   (clk_i),
        .op_i    (stack_op),
        .above_i (cell_val[i-1]),
        .below_i (cell_val[i+1]),
        .value_o (cell_val[i])
      );
    end
  end

  // ---------------------------------------------------------------- arithmetic
  assign opnd_b    = cell_val[0];
  assign opnd_a    = cell_val[1];
  assign sum       = opnd_a + opnd_b;
  assign dif       = opnd_a - opnd_b;
  assign prod      = opnd_a * opnd_b;
  assign is_digit  = (in_item_i.ch >= pee_pkg::CH_ZERO) && (in_item_i.ch <= pee_pkg::CH_NINE);
  assign digit_val = {{(DataW - pee_pkg::CH_W){1'b0}}, in_item_i.ch - pee_pkg::CH_ZERO};

  assign div_req.start    = div_start;
  assign div_req.dividend = opnd_a;
  assign div_req.divisor  = opnd_b;

  pee_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- control
  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    err_n     = err_q;
    cnt_n     = count_q;
    top_n     = cell_val[0];
    stack_op  = pee_pkg::CELL_HOLD;
    div_start = 1'b0;
    produce   = 1'b0;
    fin_last  = in_item_i.last;
    if (state_q == pee_pkg::S_DIV) begin
      fin_last = last_q;
      if (div_rsp.done) begin
        produce  = 1'b1;
        stack_op = pee_pkg::CELL_POP;
        top_n    = div_rsp.quotient;
        cnt_n    = count_q - 1'b1;
      end
    end else if (in_acc) begin
      produce = 1'b1;
      // Once an error is held, the rest of the expression is ignored.
      if (err_q == pee_pkg::STATUS_OK) begin
        if (is_digit) begin
          if (count_q == CntW'(StackDepth)) begin
            err_n = pee_pkg::STATUS_OVER;
          end else begin
            stack_op = pee_pkg::CELL_PUSH;
            top_n    = digit_val;
            cnt_n    = count_q + 1'b1;
          end
        end else if (count_q < CntW'(2)) begin
          err_n = pee_pkg::STATUS_UNDER;
        end else begin
          case (in_item_i.ch)
            pee_pkg::CH_PLUS: begin
              stack_op = pee_pkg::CELL_POP;
              top_n    = sum;
              cnt_n    = count_q - 1'b1;
            end
            pee_pkg::CH_MINUS: begin
              stack_op = pee_pkg::CELL_POP;
              top_n    = dif;
              cnt_n    = count_q - 1'b1;
            end
            pee_pkg::CH_MUL: begin
              stack_op = pee_pkg::CELL_POP;
              top_n    = prod;
              cnt_n    = count_q - 1'b1;
            end
            pee_pkg::CH_DIV: begin
              if (opnd_b == '0) begin
                err_n = pee_pkg::STATUS_DIVZERO;
              end else begin
                div_start = 1'b1;
                produce   = 1'b0;
              end
            end
            default: err_n = pee_pkg::STATUS_BADCH;
          endcase
        end
      end
    end
  end

  // The closing character pops the answer; an empty stack there is underflow.
  always_comb begin
    fin_err = err_n;
    if (fin_last && err_n == pee_pkg::STATUS_OK && cnt_n == '0) begin
      fin_err = pee_pkg::STATUS_UNDER;
    end
  end

  always_comb begin
    out_d.done_res = fin_last;
    out_d.status   = fin_err;
    out_d.value    = (fin_last && fin_err == pee_pkg::STATUS_OK) ? top_n : '0;
    if (produce) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    count_d = produce ? (fin_last ? '0 : cnt_n) : count_q;
    err_d   = produce ? (fin_last ? pee_pkg::STATUS_OK : err_n) : err_q;
    last_d  = div_start ? in_item_i.last : last_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pee_pkg::S_IDLE: if (div_start) state_d = pee_pkg::S_DIV;
      pee_pkg::S_DIV:  if (div_rsp.done) state_d = pee_pkg::S_IDLE;
      default:         state_d = pee_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == pee_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
    out_valid_o = out_valid_q;
    out_item_o  = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pee_pkg::S_IDLE;
      err_q       <= pee_pkg::STATUS_OK;
      count_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      err_q       <= err_d;
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------- checks
  `PEE_ASSERT(a_count_bound, count_q <= CntW'(StackDepth), "stack count beyond depth")
  `PEE_ASSERT_IMP(a_div_out_empty, state_q == pee_pkg::S_DIV, !out_valid_q,
                  "result held while a division runs")
  `PEE_ASSERT_IMP(a_div_done_state, div_rsp.done, state_q == pee_pkg::S_DIV,
                  "divider finished with no division pending")
  `PEE_ASSERT_IMP(a_err_value_zero, out_valid_q && out_q.status != pee_pkg::STATUS_OK,
                  out_q.value == '0, "error result carries a nonzero value")
  `PEE_ASSERT_NEXT(a_close_clears, produce && fin_last,
                   count_q == '0 && err_q == pee_pkg::STATUS_OK,
                   "stack not cleared after closing an expression")

endmodule

`default_nettype wire

FILE: rtl/pee_cell.sv
// ----------------------------------------------------------------------------
// pee_cell
// One stack cell: holds one operand and trades it with its neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_cell #(
  parameter int unsigned DataW = pee_pkg::DATA_W
) (
  input  wire logic                 clk_i,
  input  wire pee_pkg::pee_cell_op_e op_i,
  input  wire logic [DataW-1:0]     above_i,
  input  wire logic [DataW-1:0]     below_i,
  output logic      [DataW-1:0]     value_o
);

  logic [DataW-1:0] value_q, value_d;

  // A push moves every entry one cell deeper; a pop pulls them one cell up.
  always_comb begin
    case (op_i)
      pee_pkg::CELL_PUSH: value_d = above_i;
      pee_pkg::CELL_POP:  value_d = below_i;
      default:            value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

FILE: rtl/pee_div.sv
// ----------------------------------------------------------------------------
// pee_div
// Iterative signed 32-bit divider, one restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pee_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pee_pkg::pee_div_req_t req_i,
  output pee_pkg::pee_div_rsp_t      rsp_o
);

  localparam int unsigned DataW = pee_pkg::DATA_W;
  localparam int unsigned CntW  = $clog2(DataW);

  pee_pkg::pee_div_state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [DataW-1:0] rem_q, quo_q, mb_q;
  logic             neg_q;

  logic [DataW-1:0] ma, mb;
  logic [DataW:0]   rem_sh, diff;

  assign ma = req_i.dividend[DataW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
  assign mb = req_i.divisor[DataW-1]  ? (~req_i.divisor + 1'b1)  : req_i.divisor;

  assign rem_sh = {rem_q, quo_q[DataW-1]};
  assign diff   = rem_sh - {1'b0, mb_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      pee_pkg::DIV_IDLE: if (req_i.start) state_d = pee_pkg::DIV_RUN;
      pee_pkg::DIV_RUN:  if (cnt_q == CntW'(DataW - 1)) state_d = pee_pkg::DIV_DONE;
      pee_pkg::DIV_DONE: state_d = pee_pkg::DIV_IDLE;
      default:           state_d = pee_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done     = (state_q == pee_pkg::DIV_DONE);
    rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pee_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == pee_pkg::DIV_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // The dividend magnitude shifts out of quo_q while quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (state_q == pee_pkg::DIV_IDLE && req_i.start) begin
      quo_q <= ma;
      mb_q  <= mb;
      rem_q <= '0;
      neg_q <= req_i.dividend[DataW-1] ^ req_i.divisor[DataW-1];
    end else if (state_q == pee_pkg::DIV_RUN) begin
      if (!diff[DataW]) begin
        rem_q <= diff[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire
